@@ rtl/core/ebid_pkg.sv @@
// Package for the build-ID note parser: transfer payload types, parser phase
// encoding and note format constants. No dependencies.
`default_nettype none

package ebid_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int HEADER_BYTES    = 12;
  localparam int REM_BITS        = 34;
  localparam logic [31:0] BUILD_ID_TYPE = 32'd3;
  localparam logic [32:0] PAD_ADD       = 33'd3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TO_DESC,
    PH_EMIT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_region;
    logic [31:0] region_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] id_byte;
    logic       is_last;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/elf_build_id_note_parser_core.sv @@
// Top level of the build-ID note parser: walks note headers byte by byte and
// forwards the descriptor bytes of the first build-ID note. Depends on ebid_pkg.
`default_nettype none

//  channel | ports                          | direction | payload
//  input   | in_valid, in_stall, in_item    | in        | in_item_t
//  result  | out_valid, out_stall, out_item | out       | out_item_t
//
//  One byte is taken per cycle while in_stall is low; a result byte appears
//  in the output register the cycle after its byte is transferred, at most
//  one result per byte. The single output register sets the rate: in_stall
//  rises only while that register is full and the result side stalls.
//  Synchronous active-low reset leaves the parser waiting for a region start.
module elf_build_id_note_parser_core
  import ebid_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_item,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_item
);

  localparam int SUM_BITS = 35;

  logic [LENGTH_BITS-1:0] rsize_r, rsize_nxt;
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [3:0]             hdr_r, hdr_nxt;
  logic [REM_BITS-1:0]    rem_r, rem_nxt;
  logic [31:0]            name_r, name_nxt;
  logic [31:0]            desc_r, desc_nxt;
  logic [31:0]            kind_r, kind_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic                   accept;
  logic                   emit;
  logic [LENGTH_BITS-1:0] cur_rsize;
  logic [LENGTH_BITS-1:0] cur_pos;
  logic [LENGTH_BITS-1:0] pos_inc;
  logic [3:0]             cur_hdr;
  phase_t                 cur_phase;
  logic [32:0]            name_pad;
  logic [32:0]            desc_pad;
  logic [SUM_BITS-1:0]    desc_end;
  logic                   desc_fits;
  logic [REM_BITS-1:0]    skip_len;
  logic [4:0]             lane_sh;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cur_rsize = in_item.first_of_region ? in_item.region_length[LENGTH_BITS-1:0] : rsize_r;
  assign cur_pos   = in_item.first_of_region ? '0 : pos_r;
  assign cur_hdr   = in_item.first_of_region ? 4'd0 : hdr_r;
  assign cur_phase = in_item.first_of_region ? PH_HEADER : phase_r;
  assign pos_inc   = cur_pos + 1'b1;
  assign lane_sh   = {cur_hdr[1:0], 3'b000};

  always_comb begin
    name_nxt = name_r;
    desc_nxt = desc_r;
    kind_nxt = kind_r;
    unique case (cur_hdr[3:2])
      2'd0:    name_nxt[lane_sh +: 8] = in_item.data_byte;
      2'd1:    desc_nxt[lane_sh +: 8] = in_item.data_byte;
      default: kind_nxt[lane_sh +: 8] = in_item.data_byte;
    endcase
  end

  assign name_pad  = ({1'b0, name_nxt} + PAD_ADD) & ~33'd3;
  assign desc_pad  = ({1'b0, desc_nxt} + PAD_ADD) & ~33'd3;
  assign desc_end  = SUM_BITS'(pos_inc) + SUM_BITS'(name_pad) + SUM_BITS'(desc_nxt);
  assign desc_fits = desc_end <= SUM_BITS'(cur_rsize);
  assign skip_len  = REM_BITS'(name_pad) + REM_BITS'(desc_pad);

  always_comb begin
    rsize_nxt = rsize_r;
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    rem_nxt   = rem_r;
    phase_nxt = phase_r;
    if (accept) begin
      rsize_nxt = cur_rsize;
      pos_nxt   = cur_pos;
      hdr_nxt   = cur_hdr;
      phase_nxt = cur_phase;
      if (cur_phase != PH_DONE) begin
        if (cur_pos >= cur_rsize) begin
          phase_nxt = PH_DONE;
        end else begin
          pos_nxt = pos_inc;
          unique case (cur_phase)
            PH_HEADER: begin
              hdr_nxt = cur_hdr + 4'd1;
              if (cur_hdr == 4'(HEADER_BYTES - 1)) begin
                hdr_nxt = 4'd0;
                if (kind_nxt == BUILD_ID_TYPE && desc_nxt != 32'd0 && desc_fits) begin
                  if (name_pad == 33'd0) begin
                    phase_nxt = PH_EMIT;
                    rem_nxt   = REM_BITS'(desc_nxt);
                  end else begin
                    phase_nxt = PH_TO_DESC;
                    rem_nxt   = REM_BITS'(name_pad);
                  end
                end else if (skip_len == '0) begin
                  phase_nxt = PH_HEADER;
                end else begin
                  phase_nxt = PH_SKIP;
                  rem_nxt   = skip_len;
                end
              end
            end
            PH_TO_DESC: begin
              rem_nxt = rem_r - 1'b1;
              if (rem_r == REM_BITS'(1)) begin
                phase_nxt = PH_EMIT;
                rem_nxt   = REM_BITS'(desc_r);
              end
            end
            PH_EMIT: begin
              rem_nxt = rem_r - 1'b1;
              if (rem_r == REM_BITS'(1)) begin
                phase_nxt = PH_DONE;
              end
            end
            PH_SKIP: begin
              rem_nxt = rem_r - 1'b1;
              if (rem_r == REM_BITS'(1)) begin
                phase_nxt = PH_HEADER;
                hdr_nxt   = 4'd0;
              end
            end
            default: phase_nxt = PH_DONE;
          endcase
        end
      end
    end
  end

  always_comb begin
    emit = accept && cur_phase == PH_EMIT && cur_pos < cur_rsize;
    out_item_nxt = out_item_r;
    if (emit) begin
      out_item_nxt.id_byte = in_item.data_byte;
      out_item_nxt.is_last = rem_r == REM_BITS'(1);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsize_r     <= '0;
      pos_r       <= '0;
      hdr_r       <= 4'd0;
      rem_r       <= '0;
      phase_r     <= PH_DONE;
      out_valid_r <= 1'b0;
    end else begin
      rsize_r     <= rsize_nxt;
      pos_r       <= pos_nxt;
      hdr_r       <= hdr_nxt;
      rem_r       <= rem_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      name_r <= name_nxt;
      desc_r <= desc_nxt;
      kind_r <= kind_nxt;
    end
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire
